// File: rtl/cp1d_pkg.sv
// Shared constants and types for the one-dimensional closest pair block.
`default_nettype none

package cp1d_pkg;

    // Point store capacity and derived widths
    localparam int MAX_POINTS = 32;
    localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // Field widths
    localparam int PT_W  = 16;
    localparam int GAP_W = 16;

    // Stream widths
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 2;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Gap reported when no pair exists (stands for infinity)
    localparam logic [GAP_W-1:0] GAP_NONE = '1;

    // One queued point
    typedef struct packed {
        logic [PT_W-1:0] point;
        logic            last_point;
    } t_item;

    // One finished result
    typedef struct packed {
        logic [GAP_W-1:0] gap;
        logic [PT_W-1:0]  pair_high;
        logic [PT_W-1:0]  pair_low;
        logic             pair_found;
        logic             too_many;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/cp1d_front.sv
// Front end: takes input transfers and queues them for the back end.
`default_nettype none

module cp1d_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: [15:0] point
    input  wire logic [cp1d_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  wire logic                           s_axis_tlast,
    output cp1d_pkg::t_item                     o_item,
    output logic                                o_item_valid,
    input  wire logic                           i_item_ready
);

    cp1d_pkg::t_item                 r_queue [cp1d_pkg::QUEUE_DEPTH];
    logic [cp1d_pkg::QPTR_W-1:0]     r_wr_ptr, n_wr_ptr;
    logic [cp1d_pkg::QPTR_W-1:0]     r_rd_ptr, n_rd_ptr;
    logic [cp1d_pkg::QCNT_W-1:0]     r_cnt, n_cnt;
    logic                            w_push, w_pop;
    cp1d_pkg::t_item                 w_in_item;

    // Unpack the incoming transfer
    always_comb begin
        w_in_item.point      = s_axis_tdata[cp1d_pkg::PT_W-1:0];
        w_in_item.last_point = s_axis_tlast;
    end

    assign s_axis_tready = (r_cnt != cp1d_pkg::QCNT_W'(cp1d_pkg::QUEUE_DEPTH));
    assign o_item_valid  = (r_cnt != '0);
    assign o_item        = r_queue[r_rd_ptr];
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign w_pop         = o_item_valid && i_item_ready;

    // Pointer and fill level update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == cp1d_pkg::QPTR_W'(cp1d_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == cp1d_pkg::QPTR_W'(cp1d_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // Queue storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= w_in_item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/cp1d_back.sv
// Back end: scans stored points, keeps the closest pair and emits results.
`default_nettype none

module cp1d_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire cp1d_pkg::t_item                i_item,
    input  wire logic                           i_item_valid,
    output logic                                o_item_ready,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // tdata: [15:0] gap, [31:16] pair_high, [47:32] pair_low
    output logic [cp1d_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // tuser: [0] pair_found, [1] too_many
    output logic [cp1d_pkg::M_TUSER_W-1:0]      m_axis_tuser
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_STORE,
        S_FINISH
    } t_state;

    t_state                          r_state, n_state;
    logic [cp1d_pkg::CNT_W-1:0]      r_count, n_count;
    logic [cp1d_pkg::CNT_W-1:0]      r_rd_idx, n_rd_idx;
    logic                            r_cmp_vld, n_cmp_vld;
    logic                            r_have, n_have;
    logic                            r_over, n_over;
    logic [cp1d_pkg::PT_W-1:0]       r_pt, n_pt;
    logic                            r_last, n_last;
    logic [cp1d_pkg::GAP_W-1:0]      r_best_gap, n_best_gap;
    logic [cp1d_pkg::PT_W-1:0]       r_best_high, n_best_high;
    logic [cp1d_pkg::PT_W-1:0]       r_best_low, n_best_low;
    logic                            r_out_vld, n_out_vld;
    cp1d_pkg::t_result               r_out, n_out;

    logic [cp1d_pkg::PT_W-1:0]       r_store [cp1d_pkg::MAX_POINTS];
    logic [cp1d_pkg::PT_W-1:0]       r_q;

    logic                            w_issue;
    logic                            w_mem_we;
    logic                            w_p_gt_q;
    logic [cp1d_pkg::PT_W-1:0]       w_hi, w_lo;
    logic [cp1d_pkg::GAP_W-1:0]      w_diff;
    logic                            w_better;

    assign o_item_ready  = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out.pair_low, r_out.pair_high, r_out.gap};
    assign m_axis_tuser  = {r_out.too_many, r_out.pair_found};

    // One stored point read per scan cycle
    assign w_issue = (r_state == S_SCAN) && (r_rd_idx < r_count);

    // Candidate pair from the new point and the point just read
    always_comb begin
        w_p_gt_q = ($signed(r_pt) > $signed(r_q));
        w_hi     = w_p_gt_q ? r_pt : r_q;
        w_lo     = w_p_gt_q ? r_q : r_pt;
        w_diff   = w_hi - w_lo;
        w_better = r_cmp_vld && (!r_have || (w_diff < r_best_gap));
    end

    // Next state and datapath
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rd_idx    = r_rd_idx;
        n_cmp_vld   = w_issue;
        n_have      = r_have;
        n_over      = r_over;
        n_pt        = r_pt;
        n_last      = r_last;
        n_best_gap  = r_best_gap;
        n_best_high = r_best_high;
        n_best_low  = r_best_low;
        n_out_vld   = r_out_vld;
        n_out       = r_out;
        w_mem_we    = 1'b0;

        if (r_out_vld && m_axis_tready) begin
            n_out_vld = 1'b0;
        end

        if (w_issue) begin
            n_rd_idx = r_rd_idx + 1'b1;
        end

        // Strictly smaller gap replaces, so the oldest tie wins
        if (w_better) begin
            n_best_gap  = w_diff;
            n_best_high = w_hi;
            n_best_low  = w_lo;
            n_have      = 1'b1;
        end

        case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    n_pt   = i_item.point;
                    n_last = i_item.last_point;
                    if (r_count < cp1d_pkg::CNT_W'(cp1d_pkg::MAX_POINTS)) begin
                        n_rd_idx = '0;
                        n_state  = (r_count == '0) ? S_STORE : S_SCAN;
                    end else begin
                        // store full: drop the point
                        n_over  = 1'b1;
                        n_state = i_item.last_point ? S_FINISH : S_IDLE;
                    end
                end
            end
            S_SCAN: begin
                if (!w_issue && !r_cmp_vld) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                w_mem_we = 1'b1;
                n_count  = r_count + 1'b1;
                n_state  = r_last ? S_FINISH : S_IDLE;
            end
            S_FINISH: begin
                if (!r_out_vld || m_axis_tready) begin
                    n_out_vld            = 1'b1;
                    n_out.gap            = r_have ? r_best_gap : cp1d_pkg::GAP_NONE;
                    n_out.pair_high      = r_have ? r_best_high : '0;
                    n_out.pair_low       = r_have ? r_best_low : '0;
                    n_out.pair_found     = r_have;
                    n_out.too_many       = r_over;
                    n_count              = '0;
                    n_have               = 1'b0;
                    n_over               = 1'b0;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
            r_have    <= 1'b0;
            r_over    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_rd_idx  <= n_rd_idx;
            r_cmp_vld <= n_cmp_vld;
            r_have    <= n_have;
            r_over    <= n_over;
            r_out_vld <= n_out_vld;
        end
        r_pt        <= n_pt;
        r_last      <= n_last;
        r_best_gap  <= n_best_gap;
        r_best_high <= n_best_high;
        r_best_low  <= n_best_low;
        r_out       <= n_out;
    end

    // Point store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_store[r_count[cp1d_pkg::IDX_W-1:0]] <= r_pt;
        end
        r_q <= r_store[r_rd_idx[cp1d_pkg::IDX_W-1:0]];
    end

endmodule

`default_nettype wire

// File: rtl/closest_pair_1d_top.sv
// Top level of the one-dimensional closest pair block.
//
// Channel   Dir  Fields
// s_axis    in   tdata[15:0] point, tlast last_point
// m_axis    out  tdata[15:0] gap, [31:16] pair_high, [47:32] pair_low;
//                tuser[0] pair_found, [1] too_many
//
// A stored point passes through the back end as pop, one store read per stored
// point, the registered read, a check that the scan has drained, and the write,
// or as pop and write when the store is still empty; a dropped point is only popped.
// The final point of a set then loads the result register, which waits while an
// earlier result is still waiting on m_axis_tready.
// Synchronous active-low reset empties the queue and the store; no clearing
// pass is needed. Input transfers are queued four deep while the back end
// works; a waiting result stops the back end only when the next set has ended.
`default_nettype none

module closest_pair_1d_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: [15:0] point
    input  wire logic [cp1d_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  wire logic                           s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // tdata: [15:0] gap, [31:16] pair_high, [47:32] pair_low
    output logic [cp1d_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // tuser: [0] pair_found, [1] too_many
    output logic [cp1d_pkg::M_TUSER_W-1:0]      m_axis_tuser
);

    cp1d_pkg::t_item w_item;
    logic            w_item_valid;
    logic            w_item_ready;

    // Input queue
    cp1d_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .o_item        (w_item),
        .o_item_valid  (w_item_valid),
        .i_item_ready  (w_item_ready)
    );

    // Scan and result
    cp1d_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (w_item),
        .i_item_valid  (w_item_valid),
        .o_item_ready  (w_item_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // No pair: gap reads as infinity and both points as zero
    a_no_pair_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |->
        (m_axis_tdata == {32'd0, cp1d_pkg::GAP_NONE}))
        else $error("no-pair result carries stale fields");

    // A found pair is ordered and its gap is the exact difference
    a_pair_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |->
        (($signed(m_axis_tdata[31:16]) >= $signed(m_axis_tdata[47:32])) &&
         (m_axis_tdata[15:0] == 16'(m_axis_tdata[31:16] - m_axis_tdata[47:32]))))
        else $error("closest pair result inconsistent");

    // Queue comes out of reset empty and ready
    a_ready_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (s_axis_tready && !m_axis_tvalid))
        else $error("block not empty after reset");

endmodule

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for the one-dimensional closest pair block: streamed point sets against a predictor.
module testbench;
    import cp1d_pkg::*;

    localparam int ITEM_TARGET  = 1650;
    localparam int QUIET_FROM   = 1450;
    localparam int STALL_LIMIT  = 3000;
    localparam int TAIL_CYCLES  = 200;

    // Closest-pair predictor plus queue of the set reports still owed by the block
    class closest_pair_board;
        logic signed [PT_W-1:0]  set_points [MAX_POINTS];
        int unsigned             n_stored;
        logic [GAP_W-1:0]        min_gap;
        logic signed [PT_W-1:0]  min_high;
        logic signed [PT_W-1:0]  min_low;
        bit                      paired;
        bit                      dropped;
        t_result                 owed_reports [$];
        int unsigned             errors;

        function new();
            errors = 0;
            clear_set();
        endfunction

        function void clear_set();
            n_stored = 0;
            min_gap  = '1;
            min_high = '0;
            min_low  = '0;
            paired   = 1'b0;
            dropped  = 1'b0;
        endfunction

        // Note one accepted point; a marked point closes the set and owes a report
        function void take_point(logic signed [PT_W-1:0] pt, bit is_last);
            logic signed [PT_W-1:0] hi;
            logic signed [PT_W-1:0] lo;
            logic [GAP_W-1:0]       d;
            t_result                rep;
            if (n_stored < MAX_POINTS) begin
                // oldest first, so the earliest pair wins a tie
                for (int i = 0; i < n_stored; i++) begin
                    hi = (pt > set_points[i]) ? pt : set_points[i];
                    lo = (pt > set_points[i]) ? set_points[i] : pt;
                    d  = hi - lo;
                    if (!paired || d < min_gap) begin
                        min_gap  = d;
                        min_high = hi;
                        min_low  = lo;
                        paired   = 1'b1;
                    end
                end
                set_points[n_stored] = pt;
                n_stored++;
            end else begin
                dropped = 1'b1;
            end
            if (is_last) begin
                rep.gap        = paired ? min_gap : GAP_NONE;
                rep.pair_high  = paired ? min_high : '0;
                rep.pair_low   = paired ? min_low : '0;
                rep.pair_found = paired;
                rep.too_many   = dropped;
                owed_reports.push_back(rep);
                clear_set();
            end
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                errors++;
                $error("%s: expected %h, got %h", name, want, got);
            end
        endfunction

        // Check one output transfer against the oldest owed report
        function void check_report(logic [M_TDATA_W-1:0] data, logic [M_TUSER_W-1:0] user);
            t_result want;
            if (owed_reports.size() == 0) begin
                errors++;
                $error("report with none owed: tdata %h tuser %b", data, user);
                return;
            end
            want = owed_reports.pop_front();
            compare_field("gap", want.gap, data[15:0]);
            compare_field("pair_high", want.pair_high, data[31:16]);
            compare_field("pair_low", want.pair_low, data[47:32]);
            compare_field("pair_found", 16'(want.pair_found), 16'(user[0]));
            compare_field("too_many", 16'(want.too_many), 16'(user[1]));
        endfunction

        function int owed();
            return owed_reports.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic [S_TDATA_W-1:0]  s_data  = '0;
    logic                  s_last  = 1'b0;
    logic                  m_ready = 1'b0;
    logic                  s_axis_tready;
    logic                  m_axis_tvalid;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic [M_TUSER_W-1:0]  m_axis_tuser;

    closest_pair_board sb;
    int unsigned       n_sent = 0;
    bit                quiet = 1'b0;
    int unsigned       stall_left = 0;
    int unsigned       idle_cycles = 0;

    closest_pair_1d_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .s_axis_tlast  (s_last),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Offer one point, with an occasional gap first, and wait for its transfer
    task automatic send_point(input logic [PT_W-1:0] pt, input bit is_last);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= pt;
        s_last  <= is_last;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.take_point(pt, is_last);
        n_sent++;
    endtask

    task automatic send_set(input logic [PT_W-1:0] pts [$]);
        foreach (pts[k]) send_point(pts[k], k == pts.size() - 1);
    endtask

    // Hold the sender off until every owed report has come back
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        do @(posedge i_clk); while (sb.owed() != 0);
    endtask

    // One random set of len points: random values, neighbours of a base, extremes and repeats
    task automatic random_set(input int unsigned len);
        logic [PT_W-1:0] pts [$];
        logic [PT_W-1:0] base;
        int unsigned     pick;
        base = 16'($urandom);
        for (int n = 0; n < len; n++) begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
                pts.push_back(16'($urandom));
            else if (pick < 8)
                pts.push_back(base + 16'($urandom_range(0, 15)) - 16'd8);
            else if (pick == 8)
                case ($urandom_range(0, 3))
                    0: pts.push_back(16'h8000);
                    1: pts.push_back(16'h7fff);
                    2: pts.push_back(16'h0000);
                    default: pts.push_back(16'hffff);
                endcase
            else if (pts.size() != 0)
                pts.push_back(pts[$urandom_range(0, pts.size() - 1)]);
            else
                pts.push_back(base);
        end
        send_set(pts);
    endtask

    // Stimulus
    initial begin
        logic [PT_W-1:0] pts [$];
        int unsigned     r;
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // lone point: no pair
        pts = '{16'd100};
        send_set(pts);
        // extremes: widest gap with a pair present
        pts = '{16'h8000, 16'h7fff};
        send_set(pts);
        // equal points
        pts = '{16'd5, 16'd5};
        send_set(pts);
        // tie: the earlier pair of gap 10 stays
        pts = '{16'd0, 16'd10, 16'd20};
        send_set(pts);
        // gap shrinks to one, then to nothing
        pts = '{16'hffff, 16'h0000, 16'h7fff, 16'h8000, 16'h0000};
        send_set(pts);
        pts = '{16'd7, 16'hfff9, 16'd3, 16'd3};
        send_set(pts);
        hold_until_drained();

        // exactly full, then two dropped with the mark on a dropped point
        random_set(MAX_POINTS);
        random_set(MAX_POINTS + 2);

        while (n_sent < ITEM_TARGET) begin
            r = $urandom_range(0, 11);
            if (r == 0)
                random_set($urandom_range(30, 40));
            else if (r < 3)
                random_set($urandom_range(1, 2));
            else
                random_set($urandom_range(3, 10));
            if (n_sent >= QUIET_FROM)
                quiet = 1'b1;
            if ($urandom_range(0, 39) == 0)
                hold_until_drained();
        end

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Result side: check each transfer, stall in short bursts
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_ready)
            sb.check_report(m_axis_tdata, m_axis_tuser);
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            m_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 3);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: too long without any transfer ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_axis_tready) || (m_axis_tvalid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// File: closest_pair_1d_top.f
rtl/cp1d_pkg.sv
rtl/cp1d_front.sv
rtl/cp1d_back.sv
rtl/closest_pair_1d_top.sv
bench/testbench.sv
